@@ rtl/idle_gap_packet_framer_core_macros.svh @@
// assertion macros shared by the framer rtl
`ifndef IDLE_GAP_PACKET_FRAMER_CORE_MACROS_SVH
`define IDLE_GAP_PACKET_FRAMER_CORE_MACROS_SVH

// condition holds on every clock edge outside reset
`define IGPF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("framer invariant violated");

// antecedent implies consequent in the same cycle
`define IGPF_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer implication violated");

`endif

@@ rtl/igpf_pkg.sv @@
package igpf_pkg;

    localparam int BUF_SIZE_DEF = 64;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd50;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    // back part reports a drained bank to the front part
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

endpackage

@@ rtl/idle_gap_packet_framer_core.sv @@
// idle gap packet framer
// input channel i_valid/o_ready carries one transaction per received byte
// (action = byte) or per time tick (action = tick). bytes are gathered into
// one of two store banks; a packet closes when the bank holds BUF_SIZE-1
// bytes or when idle_limit ticks pass without a byte while bytes are held.
// output channel o_valid/i_ready carries the packet: a length transaction,
// then the bytes in arrival order, last set on the final one.
// idle_limit is written through i_cfg_we/i_cfg_wdata at any clock edge.
// a closed packet drains through the back part, paced by the registered
// store read (one read and one output load per byte).
// the front part stalls only while the bank it writes is still draining,
// so one packet can be collected while the previous one drains.
// when the receiver holds i_ready low the output register holds its
// transaction and draining pauses; input stalls once both banks are full.
// reset (synchronous, active low) empties both banks and the command queue
// and sets idle_limit to 50; no clearing pass is needed.
`include "idle_gap_packet_framer_core_macros.svh"

module idle_gap_packet_framer_core
    import igpf_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEF,
    localparam int STORE_DEPTH = BUF_SIZE - 1,
    localparam int IDX_W = $clog2(STORE_DEPTH),
    localparam int CNT_W = $clog2(BUF_SIZE)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic           push;
    logic           pop;
    logic [CNT_W:0] cmd_in;
    logic [CNT_W:0] cmd_out;
    logic           q_empty;
    logic           q_full;
    logic           we;
    logic [IDX_W:0] waddr;
    logic [7:0]     wdata;
    logic [IDX_W:0] raddr;
    logic [7:0]     rdata;
    t_done          done;
    logic [1:0]     pend;

    igpf_front #(
        .BUF_SIZE(BUF_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_done     (done),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd_in),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_pend     (pend)
    );

    igpf_queue #(
        .WIDTH(CNT_W + 1)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd_in),
        .i_pop  (pop),
        .o_data (cmd_out),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    igpf_ram #(
        .WIDTH(8),
        .DEPTH(2 << IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    igpf_back #(
        .BUF_SIZE(BUF_SIZE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_out),
        .i_q_empty(q_empty),
        .o_pop    (pop),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_done   (done),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    `IGPF_ASSERT_ALWAYS(a_queue_no_overflow, !(push && q_full))
    `IGPF_ASSERT_IMPLIES(a_done_bank_pending, done.valid, pend[done.bank])
    `IGPF_ASSERT_IMPLIES(a_queued_bank_pending, !q_empty, pend != 2'b00)

endmodule

@@ rtl/igpf_ram.sv @@
module igpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/igpf_queue.sv @@
module igpf_queue #(
    parameter int WIDTH = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [1:0]       r_n, n_n;
    logic [WIDTH-1:0] r_q0, n_q0;
    logic [WIDTH-1:0] r_q1, n_q1;

    always_comb begin
        n_n  = r_n;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (i_pop && r_n != 2'd0) begin
            n_q0 = r_q1;
            n_n  = n_n - 2'd1;
        end
        if (i_push && r_n != 2'd2) begin
            if (n_n == 2'd0) begin
                n_q0 = i_data;
            end else begin
                n_q1 = i_data;
            end
            n_n = n_n + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else begin
            r_n <= n_n;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_data  = r_q0;
    assign o_empty = (r_n == 2'd0);
    assign o_full  = (r_n == 2'd2);

endmodule

@@ rtl/igpf_front.sv @@
module igpf_front
    import igpf_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEF,
    localparam int STORE_DEPTH = BUF_SIZE - 1,
    localparam int IDX_W = $clog2(STORE_DEPTH),
    localparam int CNT_W = $clog2(BUF_SIZE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in                i_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  t_done              i_done,
    input  logic               i_q_full,
    output logic               o_push,
    output logic [CNT_W:0]     o_cmd,
    output logic               o_we,
    output logic [IDX_W:0]     o_waddr,
    output logic [7:0]         o_wdata,
    output logic [1:0]         o_pend
);

    logic [15:0]      r_limit;
    logic [15:0]      r_idle, n_idle;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_pend, n_pend;
    logic             acc;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      idle_inc;
    logic             emit;

    assign o_ready  = !r_pend[r_wbank] && !i_q_full;
    assign acc      = i_valid && o_ready;
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign idle_inc = r_idle + 16'd1;

    always_comb begin
        n_idle  = r_idle;
        n_cnt   = r_cnt;
        n_wbank = r_wbank;
        n_pend  = r_pend;
        emit    = 1'b0;
        o_cmd   = {r_wbank, r_cnt};
        if (i_done.valid) begin
            n_pend[i_done.bank] = 1'b0;
        end
        if (acc) begin
            if (i_data.action == ACT_BYTE) begin
                n_idle = '0;
                n_cnt  = cnt_inc;
                o_cmd  = {r_wbank, cnt_inc};
                if (cnt_inc == CNT_W'(STORE_DEPTH)) begin
                    emit = 1'b1;
                end
            end else begin
                n_idle = idle_inc;
                if (idle_inc >= r_limit) begin
                    n_idle = '0;
                    emit   = (r_cnt != '0);
                end
            end
        end
        if (emit) begin
            n_cnt           = '0;
            n_wbank         = !r_wbank;
            n_pend[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= IDLE_LIMIT_RST;
            r_idle  <= '0;
            r_cnt   <= '0;
            r_wbank <= 1'b0;
            r_pend  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_idle  <= n_idle;
            r_cnt   <= n_cnt;
            r_wbank <= n_wbank;
            r_pend  <= n_pend;
        end
    end

    assign o_push  = emit;
    assign o_we    = acc && (i_data.action == ACT_BYTE);
    assign o_waddr = {r_wbank, r_cnt[IDX_W-1:0]};
    assign o_wdata = i_data.data_byte;
    assign o_pend  = r_pend;

endmodule

@@ rtl/igpf_back.sv @@
module igpf_back
    import igpf_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEF,
    localparam int STORE_DEPTH = BUF_SIZE - 1,
    localparam int IDX_W = $clog2(STORE_DEPTH),
    localparam int CNT_W = $clog2(BUF_SIZE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W:0]     i_cmd,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic [IDX_W:0]     o_raddr,
    input  logic [7:0]         i_rdata,
    output t_done              o_done,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out               o_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;
    logic             slot_free;
    logic             is_last;

    assign slot_free = !r_out_valid || i_ready;
    assign is_last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_len;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        o_done      = '{valid: 1'b0, bank: r_bank};
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_bank  = i_cmd[CNT_W];
                    n_len   = i_cmd[CNT_W-1:0];
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: 8'(r_len), last: (r_len == '0)};
                    n_idx       = '0;
                    if (r_len == '0) begin
                        o_done.valid = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: i_rdata, last: is_last};
                    if (is_last) begin
                        o_done.valid = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bank <= n_bank;
        r_len  <= n_len;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_raddr = {r_bank, r_idx};
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import igpf_pkg::*;

    localparam int STORE_DEPTH  = BUF_SIZE_DEF - 1;
    localparam int RANDOM_ITEMS = 20;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_WAIT   = 40;
    localparam int WD_LIMIT     = 2000;
    localparam int N_ROWS       = 27;

    typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_MODEL, ROW_FILL} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        t_in         item;
        logic [1:0]  n_want;
        t_out        want0;
        t_out        want1;
    } t_row;

    localparam t_out NO_RES = '0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_in         i_data      = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_out        o_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    // framer state as seen from outside
    logic [7:0]  held_bytes [STORE_DEPTH];
    int          held_cnt   = 0;
    logic [15:0] idle_ticks = '0;
    logic [15:0] idle_limit = IDLE_LIMIT_RST;

    t_out        step_frames [$];
    t_out        frame_out_q [$];

    bit          send_gaps   = 1'b1;
    bit          recv_stalls = 1'b1;
    int unsigned recv_hold   = 0;
    int          n_in        = 0;
    int          n_out       = 0;
    int          n_packets   = 0;
    int          n_errors    = 0;
    int          n_limits    = 0;
    int          wd_count    = 0;

    // directed stimulus
    t_row dir_rows [N_ROWS] = '{
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, 16'd1, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'hFF}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_BYTE, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd2,
          t_out'{8'd1, 1'b0}, t_out'{8'h00, 1'b1}},
        '{ROW_TYPED, 16'd0, t_in'{ACT_BYTE, 8'hFF}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h5A}, 2'd2,
          t_out'{8'd1, 1'b0}, t_out'{8'hFF, 1'b1}},
        '{ROW_CFG, 16'd3, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_BYTE, 8'hA5}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_BYTE, 8'h5A}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_TICK, 8'hFF}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_BYTE, 8'h80}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h01}, 2'd2,
          t_out'{8'd1, 1'b0}, t_out'{8'h80, 1'b1}},
        '{ROW_CFG, 16'hFFFF, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_FILL, 16'd63, t_in'{ACT_BYTE, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_BYTE, 8'h01}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_CFG, 16'd2, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_TYPED, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd2,
          t_out'{8'd1, 1'b0}, t_out'{8'h01, 1'b1}},
        '{ROW_FILL, 16'd7, t_in'{ACT_BYTE, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES},
        '{ROW_MODEL, 16'd0, t_in'{ACT_TICK, 8'h00}, 2'd0, NO_RES, NO_RES}
    };

    idle_gap_packet_framer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic void close_frame();
        step_frames.push_back(t_out'{out_byte: 8'(held_cnt), last: held_cnt == 0});
        for (int k = 0; k < held_cnt; k++) begin
            step_frames.push_back(t_out'{out_byte: held_bytes[k], last: k == held_cnt - 1});
        end
        held_cnt = 0;
    endfunction

    function automatic void frame_input(input t_in item);
        step_frames.delete();
        if (item.action == ACT_BYTE) begin
            held_bytes[held_cnt] = item.data_byte;
            held_cnt++;
            idle_ticks = '0;
            if (held_cnt == STORE_DEPTH) begin
                close_frame();
            end
        end else begin
            idle_ticks = idle_ticks + 16'd1;
            // a zero limit behaves as one
            if (idle_ticks >= idle_limit || idle_limit == '0) begin
                idle_ticks = '0;
                if (held_cnt != 0) begin
                    close_frame();
                end
            end
        end
    endfunction

    function automatic logic [15:0] draw_limit();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 16'hFFFF;
        end else if (pick == 1) begin
            return 16'd0;
        end else if (pick == 2) begin
            return 16'($urandom_range(10, 30));
        end
        return 16'($urandom_range(1, 6));
    endfunction

    task automatic report_mismatch(input string what, input t_out got, input t_out want);
        n_errors++;
        $display("%0t: %s: got byte %02h last %0b, want byte %02h last %0b",
                 $time, what, got.out_byte, got.last, want.out_byte, want.last);
    endtask

    task automatic send_item(input t_in item);
        int gap;
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_in++;
        frame_input(item);
    endtask

    task automatic send_checked(input t_in item);
        send_item(item);
        foreach (step_frames[k]) begin
            frame_out_q.push_back(step_frames[k]);
        end
    endtask

    // only while idle: all frames out and the front part settled
    task automatic write_limit(input logic [15:0] value);
        i_valid <= 1'b0;
        while (frame_out_q.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        idle_limit = value;
        n_limits++;
    endtask

    // output transactions and receiver stalls
    always @(posedge i_clk) begin : out_mon
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            n_out++;
            if (o_data.last) begin
                n_packets++;
            end
            if (frame_out_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_data, NO_RES);
            end else begin
                want = frame_out_q.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_data, want);
                end
                if (o_data.last !== want.last) begin
                    report_mismatch("last", o_data, want);
                end
            end
            recv_hold = recv_stalls ? $urandom_range(0, 15) : 0;
        end else if (recv_hold != 0) begin
            recv_hold = recv_hold - 1;
        end
        i_ready <= (recv_hold == 0);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            wd_count = 0;
        end else begin
            wd_count++;
        end
        if (wd_count == WD_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WD_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_row row;
        int   n_rand;
        int   burst;
        int   ticks;
        int   noise;
        n_rand = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    write_limit(row.value);
                end
                ROW_FILL: begin
                    repeat (row.value) send_checked(t_in'{ACT_BYTE, 8'($urandom)});
                end
                ROW_MODEL: begin
                    send_checked(row.item);
                end
                default: begin
                    send_item(row.item);
                    if (row.n_want > 0) begin
                        frame_out_q.push_back(row.want0);
                    end
                    if (row.n_want > 1) begin
                        frame_out_q.push_back(row.want1);
                    end
                end
            endcase
        end

        // mostly byte bursts closed by an idle gap, some noise
        while (n_rand < RANDOM_ITEMS) begin
            write_limit(draw_limit());
            repeat ($urandom_range(1, 2)) begin
                send_gaps   = $urandom_range(0, 3) != 0;
                recv_stalls = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 4) != 0) begin
                    burst = $urandom_range(1, 8);
                    ticks = (idle_limit > 40) ? $urandom_range(0, 3)
                                              : idle_limit + $urandom_range(0, 2);
                    repeat (burst) send_checked(t_in'{ACT_BYTE, 8'($urandom)});
                    repeat (ticks) send_checked(t_in'{ACT_TICK, 8'($urandom)});
                    n_rand += burst + ticks;
                end else begin
                    noise = $urandom_range(1, 6);
                    repeat (noise) send_checked(t_in'{1'($urandom), 8'($urandom)});
                    n_rand += noise;
                end
            end
        end

        i_valid <= 1'b0;
        while (frame_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d byte/tick transactions (%0d random) over %0d idle limit settings",
                 n_in, n_rand, n_limits);
        $display("received %0d output transactions in %0d packets", n_out, n_packets);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
